FILE: rtl/core/efwu_pkg.sv
// Package: shared constants, codes and transaction types for the event flag unit.
package efwu_pkg;

  localparam int EVENT_BITS = 32;
  localparam int TASK_SLOTS = 16;
  localparam int TASK_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int OUTCOME_W  = 3;

  localparam logic [COUNT_W-1:0] ACTIVE_RESET = COUNT_W'(TASK_SLOTS);

  typedef enum logic [1:0] {
    ACT_SET   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2,
    ACT_WAIT  = 2'd3
  } action_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_NONE      = 3'd0,
    OUT_WOKEN     = 3'd1,
    OUT_CONSUMED  = 3'd2,
    OUT_SUSPENDED = 3'd3,
    OUT_REJECTED  = 3'd4
  } outcome_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [EVENT_BITS-1:0] event_mask;
    logic [TASK_W-1:0]     task_index;
  } req_t;

  typedef struct packed {
    logic [EVENT_BITS-1:0] event_flags;
    logic [TASK_SLOTS-1:0] woken_tasks;
    logic [OUTCOME_W-1:0]  wait_outcome;
  } rsp_t;

endpackage

FILE: rtl/core/efwu_if.sv
// Interfaces: request, result and configuration channels of the event flag unit.
interface efwu_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic [efwu_pkg::EVENT_BITS-1:0]  event_mask;
  logic [efwu_pkg::TASK_W-1:0]      task_index;

  modport source (output valid, output action, output event_mask, output task_index,
                  input ready);
  modport sink (input valid, input action, input event_mask, input task_index,
                output ready);
endinterface

interface efwu_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [efwu_pkg::EVENT_BITS-1:0]  event_flags;
  logic [efwu_pkg::TASK_SLOTS-1:0]  woken_tasks;
  logic [efwu_pkg::OUTCOME_W-1:0]   wait_outcome;

  modport source (output valid, output event_flags, output woken_tasks,
                  output wait_outcome, input ready);
  modport sink (input valid, input event_flags, input woken_tasks,
                input wait_outcome, output ready);
endinterface

interface efwu_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [efwu_pkg::COUNT_W-1:0]   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/event_flag_wait_wake_unit_top.sv
// Top level: handshake stages, slot count register and the slot table of the event flag unit.
// Event flag group shared by 16 task slots. Each request transaction (set, clear, read or wait)
// yields exactly one result transaction carrying the flags after the operation, the bitmap of
// slots a set woke, and the outcome of a wait. One transaction is taken every cycle while the
// results are taken. A request waits in the input register until it steps; the single-pass
// update of the slot table then writes the state and the result register together, and the
// result is offered from the result register until the sink takes it. The block holds at most
// two transactions; a result held off by the sink stops the input once the input register is full.
// The slot count written over cfg takes effect for the next request; write it only while idle.
module event_flag_wait_wake_unit_top (
  input  logic        clk,
  input  logic        rst,
  efwu_req_if.sink    req,
  efwu_rsp_if.source  rsp,
  efwu_cfg_if.sink    cfg
);

  efwu_pkg::req_t               req_q;
  logic                         req_valid;
  logic                         rsp_valid;
  efwu_pkg::rsp_t               rsp_q;
  efwu_pkg::rsp_t               rsp_next;
  logic [efwu_pkg::COUNT_W-1:0] active_tasks;
  logic                         advance;
  logic                         step;
  logic                         accept;

  assign advance   = !rsp_valid || rsp.ready;
  assign step      = req_valid && advance;
  assign req.ready = !req_valid || advance;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  efwu_slots u_slots (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .req          (req_q),
    .active_tasks (active_tasks),
    .rsp          (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid    <= 1'b0;
      rsp_valid    <= 1'b0;
      active_tasks <= efwu_pkg::ACTIVE_RESET;
    end else begin
      if (accept) begin
        req_valid <= 1'b1;
      end else if (step) begin
        req_valid <= 1'b0;
      end
      if (step) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg.valid) begin
        active_tasks <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q.action     <= req.action;
      req_q.event_mask <= req.event_mask;
      req_q.task_index <= req.task_index;
    end
    if (step) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.event_flags  = rsp_q.event_flags;
  assign rsp.woken_tasks  = rsp_q.woken_tasks;
  assign rsp.wait_outcome = rsp_q.wait_outcome;

endmodule

FILE: rtl/core/efwu_slots.sv
// Slot table: event register, per-task wait state and the single-pass update logic.
module efwu_slots (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  efwu_pkg::req_t               req,
  input  logic [efwu_pkg::COUNT_W-1:0] active_tasks,
  output efwu_pkg::rsp_t               rsp
);

  logic [efwu_pkg::EVENT_BITS-1:0] event_register;
  logic [efwu_pkg::EVENT_BITS-1:0] event_register_next;
  logic [efwu_pkg::TASK_SLOTS-1:0] task_pending;
  logic [efwu_pkg::TASK_SLOTS-1:0] task_pending_next;
  logic [efwu_pkg::TASK_SLOTS-1:0] task_woken;
  logic [efwu_pkg::TASK_SLOTS-1:0] task_woken_next;
  logic [efwu_pkg::EVENT_BITS-1:0] task_wait_bits [efwu_pkg::TASK_SLOTS];
  logic [efwu_pkg::EVENT_BITS-1:0] task_wait_bits_next [efwu_pkg::TASK_SLOTS];

  logic [efwu_pkg::COUNT_W-1:0]    slots;
  logic [efwu_pkg::TASK_SLOTS-1:0] in_use;
  logic [efwu_pkg::TASK_SLOTS-1:0] matched;
  logic [efwu_pkg::EVENT_BITS-1:0] consumed;
  logic [efwu_pkg::EVENT_BITS-1:0] still_needed;
  logic                            reject;
  logic [efwu_pkg::OUTCOME_W-1:0]  outcome;

  always_comb begin
    slots = (active_tasks > efwu_pkg::ACTIVE_RESET) ? efwu_pkg::ACTIVE_RESET : active_tasks;
    consumed = '0;
    still_needed = '0;
    for (int i = 0; i < efwu_pkg::TASK_SLOTS; i++) begin
      in_use[i]  = efwu_pkg::COUNT_W'(i) < slots;
      matched[i] = in_use[i] && task_pending[i] && ((task_wait_bits[i] & req.event_mask) != '0);
      if (matched[i]) begin
        consumed = consumed | (task_wait_bits[i] & req.event_mask);
      end
      if (in_use[i] && task_pending[i] && !matched[i]) begin
        still_needed = still_needed | task_wait_bits[i];
      end
    end
    reject = (req.event_mask == '0) || ({1'b0, req.task_index} >= slots);

    event_register_next = event_register;
    task_pending_next   = task_pending;
    task_woken_next     = task_woken;
    task_wait_bits_next = task_wait_bits;
    outcome             = efwu_pkg::OUT_NONE;
    rsp.woken_tasks     = '0;

    case (req.action)
      efwu_pkg::ACT_SET: begin
        event_register_next = (event_register | req.event_mask) & ~(consumed & ~still_needed);
        task_pending_next   = task_pending & ~matched;
        task_woken_next     = task_woken | matched;
        rsp.woken_tasks     = matched;
        for (int i = 0; i < efwu_pkg::TASK_SLOTS; i++) begin
          if (matched[i]) begin
            task_wait_bits_next[i] = '0;
          end
        end
      end
      efwu_pkg::ACT_CLEAR: begin
        event_register_next = event_register & ~req.event_mask;
      end
      efwu_pkg::ACT_WAIT: begin
        if (reject) begin
          outcome = efwu_pkg::OUT_REJECTED;
        end else if (task_woken[req.task_index]) begin
          task_woken_next[req.task_index] = 1'b0;
          outcome = efwu_pkg::OUT_WOKEN;
        end else if ((event_register & req.event_mask) != '0) begin
          event_register_next = event_register & ~req.event_mask;
          outcome = efwu_pkg::OUT_CONSUMED;
        end else begin
          task_pending_next[req.task_index]   = 1'b1;
          task_wait_bits_next[req.task_index] = req.event_mask;
          outcome = efwu_pkg::OUT_SUSPENDED;
        end
      end
      default: begin
      end
    endcase

    rsp.event_flags  = event_register_next;
    rsp.wait_outcome = outcome;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_register <= '0;
      task_pending   <= '0;
      task_woken     <= '0;
      for (int i = 0; i < efwu_pkg::TASK_SLOTS; i++) begin
        task_wait_bits[i] <= '0;
      end
    end else if (step) begin
      event_register <= event_register_next;
      task_pending   <= task_pending_next;
      task_woken     <= task_woken_next;
      task_wait_bits <= task_wait_bits_next;
    end
  end

endmodule
